[design/bmde_pkg.sv]
`timescale 1ns / 1ps

package bmde_pkg;

   localparam int unsigned MvWidth   = 15;
   localparam int unsigned PctWidth  = 7;
   localparam int unsigned ValWidth  = 12;
   localparam int unsigned WordWidth = 29;

   localparam logic [MvWidth-1:0]  FULL_MV     = 15'd3800;
   localparam logic [MvWidth-1:0]  EMPTY_MV    = 15'd3000;
   localparam logic [PctWidth-1:0] PCT_FULL    = 7'd100;
   // Reciprocal multipliers for exact division by ten over the ranges used here.
   localparam logic [15:0] RECIP10_MV  = 16'd52429;  // shift 19, exact below 43690
   localparam logic [12:0] RECIP10_VAL = 13'd6554;   // shift 16, exact below 16384
   localparam logic [7:0]  RECIP10_Q   = 8'd205;     // shift 11, exact below 1029
   localparam logic [3:0]  ROUND_MV    = 4'd5;

   localparam int unsigned BIT_DP      = 21;
   localparam int unsigned BIT_VOLT    = 22;
   localparam int unsigned BIT_PERCENT = 23;

   localparam logic [PctWidth-1:0] BAR_T4 = 7'd90;
   localparam logic [PctWidth-1:0] BAR_T3 = 7'd70;
   localparam logic [PctWidth-1:0] BAR_T2 = 7'd50;
   localparam logic [PctWidth-1:0] BAR_T1 = 7'd30;
   localparam logic [PctWidth-1:0] BAR_T0 = 7'd5;

   typedef struct packed {
      logic                fault;
      logic                pct_mode;
      logic [PctWidth-1:0] pct;
      logic [31:0]         prod;
   } scaled_type;

   typedef struct packed {
      logic                fault;
      logic                pct_mode;
      logic [PctWidth-1:0] pct;
      logic [3:0]          d0;
      logic [3:0]          d1;
      logic [3:0]          d2;
   } digits_type;

   function automatic logic [6:0] seg_of(input logic [3:0] digit);
      logic [6:0] seg;
      unique case (digit)
         4'd0: seg = 7'b0111111;
         4'd1: seg = 7'b0000011;
         4'd2: seg = 7'b1101101;
         4'd3: seg = 7'b1100111;
         4'd4: seg = 7'b1010011;
         4'd5: seg = 7'b1110110;
         4'd6: seg = 7'b1111110;
         4'd7: seg = 7'b0100011;
         4'd8: seg = 7'b1111111;
         4'd9: seg = 7'b1110111;
         default: seg = 7'b0000000;
      endcase
      return seg;
   endfunction

endpackage

[design/bmde_req_if.sv]
`timescale 1ns / 1ps

interface bmde_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] voltage_mv;
   logic [7:0]         status_bits;

   modport source (output valid, output voltage_mv, output status_bits, input ready);
   modport sink   (input valid, input voltage_mv, input status_bits, output ready);
endinterface

[design/bmde_rsp_if.sv]
`timescale 1ns / 1ps

interface bmde_rsp_if;
   logic        valid;
   logic        ready;
   logic [28:0] display_word;
   logic        fault;

   modport source (output valid, output display_word, output fault, input ready);
   modport sink   (input valid, input display_word, input fault, output ready);
endinterface

[design/bmde_scale.sv]
`timescale 1ns / 1ps

module bmde_scale (
   input  logic                   clock,
   input  logic                   reset,
   bmde_req_if.sink               req,
   output logic                   out_valid,
   output bmde_pkg::scaled_type   out_data,
   input  logic                   out_ready
);

   logic                             valid_ff;
   bmde_pkg::scaled_type             data_ff, data_in;
   logic                             take;
   logic [bmde_pkg::MvWidth-1:0]     mv;
   logic [15:0]                      mv_round;
   logic [bmde_pkg::MvWidth-1:0]     above;

   assign take = !valid_ff || out_ready;
   assign req.ready = take;
   assign mv = req.voltage_mv[bmde_pkg::MvWidth-1:0];
   assign mv_round = {1'b0, mv} + {12'd0, bmde_pkg::ROUND_MV};
   assign above = mv - bmde_pkg::EMPTY_MV;

   always_comb begin
      data_in.fault    = req.voltage_mv[15];
      data_in.pct_mode = req.status_bits[0];
      priority if (mv > bmde_pkg::FULL_MV) begin
         data_in.pct = bmde_pkg::PCT_FULL;
      end else if (mv <= bmde_pkg::EMPTY_MV) begin
         data_in.pct = '0;
      end else begin
         // The difference is at most 800 here, so eighths fit in seven bits.
         data_in.pct = above[9:3];
      end
      data_in.prod = mv_round * bmde_pkg::RECIP10_MV;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req.valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[design/bmde_split.sv]
`timescale 1ns / 1ps

module bmde_split (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  bmde_pkg::scaled_type   in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output bmde_pkg::digits_type   out_data,
   input  logic                   out_ready
);

   // Stage A: pick the shown value and multiply by the reciprocal of ten.
   logic                              a_valid_ff;
   logic                              a_take;
   logic                              a_fault_ff, a_mode_ff;
   logic [bmde_pkg::PctWidth-1:0]     a_pct_ff;
   logic [bmde_pkg::ValWidth-1:0]     a_val_ff, a_val_in;
   logic [24:0]                       a_prod_ff, a_prod_in;

   // Stage B: tens quotient and ones digit.
   logic                              b_valid_ff;
   logic                              b_take;
   logic                              b_fault_ff, b_mode_ff;
   logic [bmde_pkg::PctWidth-1:0]     b_pct_ff;
   logic [8:0]                        b_q1_ff, b_q1_in;
   logic [3:0]                        b_d0_ff, b_d0_in;
   logic [bmde_pkg::ValWidth-1:0]     b_tens;

   // Stage C: tens and hundreds digits.
   logic                              c_valid_ff;
   logic                              c_take;
   bmde_pkg::digits_type              c_data_ff, c_data_in;
   logic [16:0]                       c_prod;
   logic [5:0]                        c_q2;
   logic [8:0]                        c_tens;

   assign c_take   = !c_valid_ff || out_ready;
   assign b_take   = !b_valid_ff || c_take;
   assign a_take   = !a_valid_ff || b_take;
   assign in_ready = a_take;

   always_comb begin
      a_val_in  = in_data.pct_mode ? {5'd0, in_data.pct} : in_data.prod[30:19];
      a_prod_in = a_val_in * bmde_pkg::RECIP10_VAL;
   end

   always_comb begin
      b_q1_in = a_prod_ff[24:16];
      b_tens  = {b_q1_in, 3'd0} + {2'd0, b_q1_in, 1'b0};
      b_d0_in = 4'(a_val_ff - b_tens);
   end

   always_comb begin
      c_prod = b_q1_ff * bmde_pkg::RECIP10_Q;
      c_q2   = c_prod[16:11];
      c_tens = {c_q2, 3'd0} + {2'd0, c_q2, 1'b0};
      c_data_in.fault    = b_fault_ff;
      c_data_in.pct_mode = b_mode_ff;
      c_data_in.pct      = b_pct_ff;
      c_data_in.d0       = b_d0_ff;
      c_data_in.d1       = 4'(b_q1_ff - c_tens);
      // The hundreds quotient is at most 32, so mod ten is a short compare chain.
      priority if (c_q2 >= 6'd30) begin
         c_data_in.d2 = 4'(c_q2 - 6'd30);
      end else if (c_q2 >= 6'd20) begin
         c_data_in.d2 = 4'(c_q2 - 6'd20);
      end else if (c_q2 >= 6'd10) begin
         c_data_in.d2 = 4'(c_q2 - 6'd10);
      end else begin
         c_data_in.d2 = c_q2[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_take) begin
            a_valid_ff <= in_valid;
         end
         if (b_take) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_take) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_take && in_valid) begin
         a_fault_ff <= in_data.fault;
         a_mode_ff  <= in_data.pct_mode;
         a_pct_ff   <= in_data.pct;
         a_val_ff   <= a_val_in;
         a_prod_ff  <= a_prod_in;
      end
      if (b_take && a_valid_ff) begin
         b_fault_ff <= a_fault_ff;
         b_mode_ff  <= a_mode_ff;
         b_pct_ff   <= a_pct_ff;
         b_q1_ff    <= b_q1_in;
         b_d0_ff    <= b_d0_in;
      end
      if (c_take && b_valid_ff) begin
         c_data_ff <= c_data_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_data_ff;

endmodule

[design/bmde_segs.sv]
`timescale 1ns / 1ps

module bmde_segs (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  bmde_pkg::digits_type   in_data,
   output logic                   in_ready,
   bmde_rsp_if.source             rsp
);

   logic                                 valid_ff;
   logic                                 take;
   logic [bmde_pkg::WordWidth-1:0]       word_ff, word_in;
   logic                                 fault_ff;
   logic [4:0]                           bar;
   logic [20:0]                          digits;

   assign take     = !valid_ff || rsp.ready;
   assign in_ready = take;

   always_comb begin
      priority if (in_data.pct >= bmde_pkg::BAR_T4) begin
         bar = 5'b11111;
      end else if (in_data.pct >= bmde_pkg::BAR_T3) begin
         bar = 5'b11110;
      end else if (in_data.pct >= bmde_pkg::BAR_T2) begin
         bar = 5'b11100;
      end else if (in_data.pct >= bmde_pkg::BAR_T1) begin
         bar = 5'b11000;
      end else if (in_data.pct >= bmde_pkg::BAR_T0) begin
         bar = 5'b10000;
      end else begin
         bar = 5'b00000;
      end

      // Leading zeros are blanked; the ones digit always shows unless a fault clears the word.
      priority if (in_data.d2 != 4'd0) begin
         digits = {bmde_pkg::seg_of(in_data.d2), bmde_pkg::seg_of(in_data.d1),
                   bmde_pkg::seg_of(in_data.d0)};
      end else if (in_data.d1 != 4'd0) begin
         digits = {7'd0, bmde_pkg::seg_of(in_data.d1), bmde_pkg::seg_of(in_data.d0)};
      end else begin
         digits = {14'd0, bmde_pkg::seg_of(in_data.d0)};
      end

      word_in = {bar, 3'b000, digits};
      if (in_data.pct_mode) begin
         word_in[bmde_pkg::BIT_PERCENT] = 1'b1;
      end else begin
         word_in[bmde_pkg::BIT_VOLT] = 1'b1;
         word_in[bmde_pkg::BIT_DP]   = 1'b1;
      end
      if (in_data.fault) begin
         word_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         word_ff  <= word_in;
         fault_ff <= in_data.fault;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.display_word = word_ff;
   assign rsp.fault        = fault_ff;

endmodule

[design/battery_meter_display_encoder.sv]
`timescale 1ns / 1ps

// Battery meter display encoder. Each beat on req_chan carries a signed millivolt
// sample and a status byte; each beat on rsp_chan carries the 29-bit display word
// for a three-digit seven-segment battery display and a fault flag. The block is a
// five-stage pipeline (scaling, reciprocal multiply, two digit-split stages, segment
// encode into the output register): it takes one sample every cycle while rsp_chan
// is not stalled. When rsp_chan is stalled, the stages fill up in turn and
// req_chan.ready drops only once every stage holds a beat.

module battery_meter_display_encoder (
   input  logic        clock,
   input  logic        reset,
   bmde_req_if.sink    req_chan,
   bmde_rsp_if.source  rsp_chan
);

   logic                   s1_valid, s1_ready;
   bmde_pkg::scaled_type   s1_data;
   logic                   s2_valid, s2_ready;
   bmde_pkg::digits_type   s2_data;

   bmde_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .out_valid (s1_valid),
      .out_data  (s1_data),
      .out_ready (s1_ready)
   );

   bmde_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .in_ready  (s1_ready),
      .out_valid (s2_valid),
      .out_data  (s2_data),
      .out_ready (s2_ready)
   );

   bmde_segs u_segs (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_valid),
      .in_data  (s2_data),
      .in_ready (s2_ready),
      .rsp      (rsp_chan)
   );

endmodule
